// ===== rtl/core/bfpa_pkg.sv =====
// Shared types and constants for the best-fit page allocator.
package bfpa_pkg;
  localparam int unsigned NumPagesDef = 1024;
  localparam int unsigned PageBitsDef = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;

  localparam logic [0:0] REG_HEAP_BASE = 1'b0;
  localparam logic [0:0] REG_ENABLE    = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_APPEND,
    S_FIND, S_FIND_CHK, S_UNMARK, S_SHIFT, S_SHIFT_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_start;
    logic scan_step;
    logic mark_step;
    logic append;
    logic find_start;
    logic find_step;
    logic find_chk;
    logic unmark_step;
    logic shift_rd;
    logic shift_wr;
    logic finish_ok;
    logic finish_fail;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic alloc_bad;
    logic scan_done;
    logic found;
    logic mark_done;
    logic find_done;
    logic find_hit;
    logic unmark_done;
    logic shift_done;
  } stat_t;
endpackage

// ===== rtl/core/bfpa_ctrl.sv =====
// Controller state machine sequencing allocate and free commands.
module bfpa_ctrl import bfpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.is_free) begin
          cmd.find_start = 1'b1;
          state_nxt = S_FIND;
        end else if (stat.alloc_bad) begin
          cmd.finish_fail = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_done) begin
            if (stat.found) begin
              cmd.scan_start = 1'b1;
              state_nxt = S_MARK;
            end else begin
              cmd.finish_fail = 1'b1;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_done) state_nxt = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.finish_ok = 1'b1;
        state_nxt = S_DONE;
      end
      S_FIND: begin
        if (stat.find_done) begin
          cmd.finish_fail = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.find_step = 1'b1;
          state_nxt = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        cmd.find_chk = 1'b1;
        if (stat.find_hit) state_nxt = S_UNMARK;
        else state_nxt = S_FIND;
      end
      S_UNMARK: begin
        cmd.unmark_step = 1'b1;
        if (stat.unmark_done) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.finish_ok = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/bfpa_dp.sv =====
// Datapath: page bitmap, allocation table, run scanner and result registers.
module bfpa_dp import bfpa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NumPagesDef,
  parameter int unsigned PAGE_BITS = PageBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_command,
  input  logic [31:0] in_size_bytes,
  input  logic [31:0] in_free_address,
  input  logic [31:0] heap_base,
  input  logic        best_fit_enable,
  output logic [1:0]  out_status,
  output logic [31:0] out_address,
  output logic [10:0] out_page_count
);
  localparam int unsigned IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned NW = 33 - PAGE_BITS;

  logic          page_used [NUM_PAGES];
  logic [IW-1:0] tbl_start [NUM_PAGES];
  logic [CW-1:0] tbl_pages [NUM_PAGES];

  logic          cmd_r;
  logic [31:0]   faddr_r;
  logic [CW-1:0] cur_r, run_r, run_start_r;
  logic [CW-1:0] best_len_r, best_start_r, need_r, idx_r, len_r;
  logic          found_r, pg_q_r;
  logic [IW-1:0] st_q_r, sst_q_r;
  logic [CW-1:0] pc_q_r, spc_q_r;
  logic [CW-1:0] alloc_count_r;
  logic [1:0]    status_r;
  logic [31:0]   addr_r;
  logic [10:0]   pc_r;
  logic          scan_q_ok_r;

  logic [NW-1:0] need_full;
  logic [31:0]   st_addr;
  assign need_full = NW'(({1'b0, in_size_bytes} + 33'((33'd1 << PAGE_BITS) - 1)) >> PAGE_BITS);

  function automatic logic [31:0] paddr(input logic [31:0] base, input logic [IW-1:0] p);
    paddr = base + 32'(64'(p) << PAGE_BITS);
  endfunction
  assign st_addr = paddr(heap_base, st_q_r);

  // scan: cur_r index of page whose registered bit is pg_q_r
  logic used_now;
  logic run_fits;
  assign used_now = (cur_r == CW'(NUM_PAGES)) || pg_q_r;
  assign run_fits = (run_r != '0) && (run_r >= need_r) && (!found_r || run_r < best_len_r);

  assign stat.clear_done  = (cur_r == CW'(NUM_PAGES - 1));
  assign stat.is_free     = (cmd_r == CMD_FREE);
  assign stat.alloc_bad   = !scan_q_ok_r;
  assign stat.scan_done   = used_now && (cur_r == CW'(NUM_PAGES));
  assign stat.found       = found_r || run_fits;
  assign stat.mark_done   = (len_r == CW'(1));
  assign stat.find_done   = (idx_r >= alloc_count_r);
  assign stat.find_hit    = (st_addr == faddr_r);
  assign stat.unmark_done = (len_r <= CW'(1));
  assign stat.shift_done  = (idx_r + CW'(1) >= alloc_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r         <= '0;
      alloc_count_r <= '0;
    end else begin
      if (cmd.clear_step) begin
        page_used[cur_r[IW-1:0]] <= 1'b0;
        cur_r <= cur_r + CW'(1);
      end
      if (cmd.load) begin
        cmd_r   <= in_command;
        faddr_r <= in_free_address;
        cur_r   <= '0;
        run_r   <= '0;
        run_start_r <= '0;
        best_len_r  <= CW'(NUM_PAGES);
        found_r     <= 1'b0;
        need_r      <= CW'(need_full);
        scan_q_ok_r <= (in_size_bytes != '0) && best_fit_enable &&
                       (need_full <= NW'(NUM_PAGES)) &&
                       (alloc_count_r < CW'(NUM_PAGES));
        pg_q_r <= page_used[0];
      end
      if (cmd.scan_step) begin
        if (used_now) begin
          if (run_fits) begin
            best_len_r   <= run_r;
            best_start_r <= run_start_r;
            found_r      <= 1'b1;
          end
          run_r <= '0;
        end else begin
          if (run_r == '0) run_start_r <= cur_r;
          run_r <= run_r + CW'(1);
        end
        if (cur_r < CW'(NUM_PAGES)) begin
          cur_r <= cur_r + CW'(1);
          if (cur_r + CW'(1) < CW'(NUM_PAGES))
            pg_q_r <= page_used[IW'(cur_r + CW'(1))];
        end
      end
      if (cmd.scan_start) begin
        // final run closes at the heap end
        idx_r <= run_fits ? run_start_r : best_start_r;
        len_r <= need_r;
      end
      if (cmd.mark_step) begin
        page_used[idx_r[IW-1:0]] <= 1'b1;
        idx_r <= idx_r + CW'(1);
        len_r <= len_r - CW'(1);
      end
      if (cmd.append) begin
        tbl_start[alloc_count_r[IW-1:0]] <= best_start_r[IW-1:0];
        tbl_pages[alloc_count_r[IW-1:0]] <= need_r;
        alloc_count_r <= alloc_count_r + CW'(1);
        addr_r   <= paddr(heap_base, best_start_r[IW-1:0]);
        pc_r     <= 11'(need_r);
        status_r <= ST_OK;
      end
      if (cmd.find_start) idx_r <= '0;
      if (cmd.find_step) begin
        st_q_r <= tbl_start[idx_r[IW-1:0]];
        pc_q_r <= tbl_pages[idx_r[IW-1:0]];
      end
      if (cmd.find_chk) begin
        if (st_addr == faddr_r) begin
          len_r <= pc_q_r;
          cur_r <= CW'(st_q_r);
        end else idx_r <= idx_r + CW'(1);
      end
      if (cmd.unmark_step) begin
        if (len_r != '0) page_used[cur_r[IW-1:0]] <= 1'b0;
        cur_r <= cur_r + CW'(1);
        len_r <= len_r - CW'(1);
      end
      if (cmd.shift_rd) begin
        sst_q_r <= tbl_start[IW'(idx_r + CW'(1))];
        spc_q_r <= tbl_pages[IW'(idx_r + CW'(1))];
      end
      if (cmd.shift_wr) begin
        tbl_start[idx_r[IW-1:0]] <= sst_q_r;
        tbl_pages[idx_r[IW-1:0]] <= spc_q_r;
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.finish_ok && cmd_r == CMD_FREE) begin
        alloc_count_r <= alloc_count_r - CW'(1);
        addr_r   <= faddr_r;
        pc_r     <= 11'(pc_q_r);
        status_r <= ST_OK;
      end
      if (cmd.finish_fail) begin
        addr_r   <= '0;
        pc_r     <= '0;
        status_r <= (cmd_r == CMD_FREE) ? ST_NOT_FND : ST_NO_SPACE;
      end
    end
  end

  assign out_status     = status_r;
  assign out_address    = addr_r;
  assign out_page_count = pc_r;
endmodule

// ===== rtl/core/best_fit_page_allocator.sv =====
// Top level of the best-fit page allocator: register port, controller and datapath.
// Usage: a command word enters on in_* (valid/ready); one result word leaves
// on out_* (valid/ready). Write heap_base (0x0) and best_fit_enable (0x4)
// over the cfg_ APB port only while the block is idle.
// After reset a clearing pass zeroes the page bitmap; in_ready stays low during it.
// Allocate: a bitmap scan, then the pages marked one at a time and the entry recorded;
// the scan reads one bitmap bit per cycle.
// Free: table entries are searched in turn, pages are released one at a time and
// later entries shift down in compaction; the table memory has one access a cycle.
// One command is in flight at a time; in_ready is low from acceptance until
// the result word is taken. If the receiver stalls, the result holds on out_*.
module best_fit_page_allocator import bfpa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NumPagesDef,
  parameter int unsigned PAGE_BITS = PageBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_size_bytes,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_address,
  output logic [10:0] out_page_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] heap_base_r;
  logic        enable_r;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= 32'h8000_0000;
      enable_r    <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_HEAP_BASE: heap_base_r <= cfg_pwdata;
        REG_ENABLE:    enable_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HEAP_BASE: cfg_prdata = heap_base_r;
      REG_ENABLE:    cfg_prdata = {31'd0, enable_r};
      default:       cfg_prdata = '0;
    endcase
  end

  bfpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  bfpa_dp #(.NUM_PAGES(NUM_PAGES), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_command, .in_size_bytes, .in_free_address,
    .heap_base(heap_base_r), .best_fit_enable(enable_r),
    .out_status, .out_address, .out_page_count
  );
endmodule
